[src/mbld_pkg.sv]
// shared types and constants for the multi-button lockout debouncer
// no dependencies; used by every module in src
package mbld_pkg;

  localparam int MAX_BUTTONS         = 16;
  localparam int DEF_NUM_BUTTONS     = 16;
  localparam int DEF_MAIN_GROUP_SIZE = 8;
  localparam int TIME_W              = 64;
  localparam int FREEZE_W            = 16;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 16;

  localparam logic [FREEZE_W-1:0] FREEZE_RESET = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREEZE_TIME  = 2'd0,
    REG_MAIN_ACTIVE  = 2'd1,
    REG_AUX_ACTIVE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_BUTTONS-1:0] raw_levels;
    logic [TIME_W-1:0]      now_us;
  } in_item_t;

  typedef struct packed {
    logic [MAX_BUTTONS-1:0] pressed_bits;
    logic                   any_raw_pressed;
  } out_item_t;

  typedef struct packed {
    logic                take;
    logic                active_high;
    logic [FREEZE_W-1:0] freeze_time;
  } lane_ctl_t;

  typedef struct packed {
    logic pressed;
    logic debounced;
  } lane_stat_t;

endpackage

[src/mbld_lane.sv]
// one button lane: debounced state and lock-out deadline
// depends on mbld_pkg
module mbld_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mbld_pkg::lane_ctl_t                 ctl_i,
  input  logic                                raw_i,
  input  logic [mbld_pkg::TIME_W-1:0]         now_i,
  output mbld_pkg::lane_stat_t                stat_o
);

  logic                          deb_r;
  logic                          deb_nxt;
  logic [mbld_pkg::TIME_W-1:0]   deadline_r;
  logic [mbld_pkg::TIME_W-1:0]   deadline_nxt;
  logic                          pressed;
  logic                          flip;

  assign pressed = (raw_i == ctl_i.active_high);
  assign flip    = (now_i >= deadline_r) && (pressed != deb_r);

  always_comb begin
    deb_nxt      = deb_r;
    deadline_nxt = deadline_r;
    if (flip) begin
      deb_nxt      = pressed;
      deadline_nxt = now_i + mbld_pkg::TIME_W'(ctl_i.freeze_time);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r      <= 1'b0;
      deadline_r <= '0;
    end else if (ctl_i.take) begin
      deb_r      <= deb_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  assign stat_o.pressed   = pressed;
  assign stat_o.debounced = deb_nxt;

endmodule

[src/mbld_merge.sv]
// merges lane status into one result item
// depends on mbld_pkg
module mbld_merge (
  input  mbld_pkg::lane_stat_t [mbld_pkg::MAX_BUTTONS-1:0] stat_i,
  output mbld_pkg::out_item_t                               item_o
);

  always_comb begin
    item_o = '0;
    for (int i = 0; i < mbld_pkg::MAX_BUTTONS; i++) begin
      item_o.pressed_bits[i] = stat_i[i].debounced;
      item_o.any_raw_pressed = item_o.any_raw_pressed | stat_i[i].pressed;
    end
  end

endmodule

[src/multi_button_lockout_debouncer.sv]
// top level of the multi-button lockout debouncer: config registers, lanes, output register
// depends on mbld_pkg, mbld_lane and mbld_merge
// Takes one item per clock cycle while in_stall is low; the result is registered and
// appears in the cycle after the item is taken. Every button has its own lane that does
// the deadline compare and the now-plus-freeze add combinationally, so the 64-bit
// compare and add in a lane set the clock path. A single output register holds the result;
// input stall rises only while that register is full and the output side stalls.
module multi_button_lockout_debouncer #(
  parameter int NUM_BUTTONS     = mbld_pkg::DEF_NUM_BUTTONS,
  parameter int MAIN_GROUP_SIZE = mbld_pkg::DEF_MAIN_GROUP_SIZE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mbld_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mbld_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbld_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [mbld_pkg::FREEZE_W-1:0] freeze_r;
  logic                          main_hi_r;
  logic                          aux_hi_r;
  logic                          take;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  mbld_pkg::out_item_t           out_data_r;
  mbld_pkg::out_item_t           merged;
  logic [mbld_pkg::MAX_BUTTONS-1:0]                  lane_mask;
  mbld_pkg::lane_stat_t [mbld_pkg::MAX_BUTTONS-1:0]  lane_stat;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freeze_r  <= mbld_pkg::FREEZE_RESET;
      main_hi_r <= 1'b0;
      aux_hi_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbld_pkg::REG_FREEZE_TIME: freeze_r  <= cfg_data[mbld_pkg::FREEZE_W-1:0];
        mbld_pkg::REG_MAIN_ACTIVE: main_hi_r <= cfg_data[0];
        mbld_pkg::REG_AUX_ACTIVE:  aux_hi_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  // lanes
  for (genvar g = 0; g < mbld_pkg::MAX_BUTTONS; g++) begin : g_lane
    if (g < NUM_BUTTONS) begin : g_on
      mbld_pkg::lane_ctl_t ctl;
      assign ctl.take        = take;
      assign ctl.active_high = (g < MAIN_GROUP_SIZE) ? main_hi_r : aux_hi_r;
      assign ctl.freeze_time = freeze_r;
      assign lane_mask[g]    = 1'b1;

      mbld_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_i  (ctl),
        .raw_i  (in_data.raw_levels[g]),
        .now_i  (in_data.now_us),
        .stat_o (lane_stat[g])
      );
    end else begin : g_off
      assign lane_mask[g] = 1'b0;
      assign lane_stat[g] = '0;
    end
  end

  mbld_merge u_merge (
    .stat_i (lane_stat),
    .item_o (merged)
  );

  // output register
  assign out_valid_nxt = take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("taken item produced no result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !in_valid |=> !out_valid)
    else $error("result repeated without a new item");

  a_unused_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressed_bits & ~lane_mask) == '0)
    else $error("pressed bit set beyond button count");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule

[test/tb_multi_button_lockout_debouncer.sv]
// self-checking testbench for multi_button_lockout_debouncer: directed and random pin samples
// with a built-in lockout predictor, random gaps on the input and random stalls on the output
// depends on mbld_pkg and the multi_button_lockout_debouncer rtl
`timescale 1ns / 100ps

module tb_multi_button_lockout_debouncer;
  import mbld_pkg::*;

  localparam int NUM_BTN     = DEF_NUM_BUTTONS;
  localparam int MAIN_BTN    = DEF_MAIN_GROUP_SIZE;
  localparam int PHASE_ITEMS = 310;
  localparam int LONG_HOLD   = 150;
  localparam int END_PAD     = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state
  logic [FREEZE_W-1:0] freeze_us = FREEZE_RESET;
  logic                main_hi   = 1'b0;
  logic                aux_hi    = 1'b0;
  logic                db_state  [NUM_BTN];
  logic [TIME_W-1:0]   unlock_at [NUM_BTN];

  in_item_t  sample_q[$];
  out_item_t debounced_q[$];
  out_item_t want;

  logic [TIME_W-1:0] sim_us   = '0;
  logic [15:0]       held_raw = '1;

  int in_flight    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int cycles       = 0;
  logic item_taken = 1'b0;
  logic res_taken  = 1'b0;
  logic next_valid;

  multi_button_lockout_debouncer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int b = 0; b < NUM_BTN; b++) begin
      db_state[b]  = 1'b0;
      unlock_at[b] = '0;
    end
  end

  function automatic out_item_t debounce_step(in_item_t s);
    out_item_t r;
    logic      hit;
    logic      level_on;
    r = '0;
    for (int b = 0; b < NUM_BTN; b++) begin
      level_on = (b < MAIN_BTN) ? main_hi : aux_hi;
      hit = (s.raw_levels[b] == level_on);
      if (hit) r.any_raw_pressed = 1'b1;
      if (s.now_us >= unlock_at[b] && hit != db_state[b]) begin
        db_state[b]  = hit;
        unlock_at[b] = s.now_us + TIME_W'(freeze_us);
      end
      r.pressed_bits[b] = db_state[b];
    end
    return r;
  endfunction

  task automatic queue_sample(input logic [15:0] raw, input logic [TIME_W-1:0] t);
    in_item_t s;
    s.raw_levels = raw;
    s.now_us     = t;
    sample_q.push_back(s);
    in_flight++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (in_flight != 0);
  endtask

  // leaves cfg_valid high so that back-to-back writes need no second assignment
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FREEZE_TIME: freeze_us = val;
      REG_MAIN_ACTIVE: main_hi   = val[0];
      REG_AUX_ACTIVE:  aux_hi    = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] ft, input logic mh, input logic ah);
    cfg_write(REG_FREEZE_TIME, ft);
    cfg_write(REG_MAIN_ACTIVE, CFG_DATA_W'(mh));
    cfg_write(REG_AUX_ACTIVE, CFG_DATA_W'(ah));
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    int unsigned ft;
    int unsigned pick;
    ft = freeze_us;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) sim_us += $urandom_range(ft / 4 + 1, 0);
      else if (pick < 80) sim_us += $urandom_range(ft + ft / 4 + 1, ft - ft / 4);
      else if (pick < 90) sim_us += $urandom_range(3, 0);
      else if (pick < 94) sim_us -= $urandom_range(ft + 10, 0);
      else if (pick < 97) sim_us = {$urandom, $urandom};
      else sim_us = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(ft + 20, 0);
      if ($urandom_range(4, 0) == 0) held_raw ^= 16'(1 << $urandom_range(15, 0));
      pick = $urandom_range(9, 0);
      if (pick < 5) queue_sample(held_raw, sim_us);
      else if (pick < 9) queue_sample(held_raw ^ 16'(1 << $urandom_range(15, 0)), sim_us);
      else queue_sample(16'($urandom), sim_us);
    end
  endtask

  task automatic run_phase(input logic [15:0] ft, input logic mh, input logic ah);
    wait_idle();
    apply_settings(ft, mh, ah);
    queue_random(PHASE_ITEMS);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && item_taken) begin
        next_valid = 1'b0;
        items_sent++;
        gap_left = ((items_sent / 64) % 3 == 1) ? 0 : $urandom_range(6, 0);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() > 0) begin
          in_data <= sample_q.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) begin
        stall_left = ((results_seen / 64) % 3 == 0) ? 0 : $urandom_range(6, 0);
        if (results_seen % 1000 == 250 || results_seen % 1000 == 700) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on every accepted item, check every accepted result
  always @(posedge clk) begin
    item_taken = rst_n && in_valid && !in_stall;
    res_taken  = rst_n && out_valid && !out_stall;
    if (item_taken) debounced_q.push_back(debounce_step(in_data));
    if (res_taken) begin
      results_seen++;
      if (debounced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: pressed_bits %h any_raw_pressed %b",
                   results_seen, out_data.pressed_bits, out_data.any_raw_pressed);
      end else begin
        want = debounced_q.pop_front();
        in_flight--;
        if (out_data.pressed_bits !== want.pressed_bits ||
            out_data.any_raw_pressed !== want.any_raw_pressed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: pressed_bits exp %h got %h, any_raw_pressed exp %b got %b",
                     results_seen, want.pressed_bits, out_data.pressed_bits,
                     want.any_raw_pressed, out_data.any_raw_pressed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;

    // reset settings: both groups active low, 3000 us lockout
    queue_sample(16'hFFFF, 64'd0);
    queue_sample(16'h0000, 64'd0);
    queue_sample(16'hFFFF, 64'd2999);
    queue_sample(16'hFFFF, 64'd3000);
    queue_sample(16'h00FF, 64'd3000);
    queue_sample(16'hFF00, 64'd6000);
    queue_sample(16'h7FFE, 64'd9000);
    queue_sample(16'h0000, 64'd100);
    // deadline wraps past the top of the time range
    queue_sample(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_sample(16'h0000, 64'hFFFF_FFFF_FFFF_FFF1);
    queue_sample(16'hAAAA, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_sample(16'h5555, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    // zero lockout, active high
    apply_settings(16'd0, 1'b1, 1'b1);
    queue_sample(16'hFFFF, 64'd5);
    queue_sample(16'h0000, 64'd5);
    queue_sample(16'h8001, 64'd6);
    queue_sample(16'h0180, 64'd6);
    queue_sample(16'h0000, 64'd7);
    wait_idle();

    // longest lockout, mixed polarity
    apply_settings(16'hFFFF, 1'b1, 1'b0);
    queue_sample(16'h00FF, 64'd10);
    queue_sample(16'h0000, 64'd65544);
    queue_sample(16'h0000, 64'd65545);
    queue_sample(16'hFF00, 64'd131080);
    queue_sample(16'hFFFF, 64'd200000);

    run_phase(16'd0, 1'b0, 1'b1);
    run_phase(16'hFFFF, 1'b1, 1'b1);
    run_phase(FREEZE_RESET, 1'b0, 1'b0);
    run_phase(16'd7, 1'b1, 1'b0);
    run_phase(16'($urandom_range(2000, 1)), 1'($urandom), 1'($urandom));
    run_phase(16'd1, 1'b0, 1'b0);

    wait_idle();
    repeat (END_PAD) @(posedge clk);
    if (mismatches == 0 && debounced_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
